@@ hw/rtl/mbrc_pkg.sv @@
// Package for the Modbus request checker: request, response and register types,
// status and function codes, register indexes.
// No dependencies.
package mbrc_pkg;

  // Configuration port widths.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_COIL_COUNT     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DISCRETE_COUNT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLDING_COUNT  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_INPUT_COUNT    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CHECKSUM_LEN   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_REPLY_CAPACITY = 3'd5;

  // Verdict codes.
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_FORMAT      = 3'd1;
  localparam logic [2:0] ST_ADDR        = 3'd2;
  localparam logic [2:0] ST_SPACE       = 3'd3;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd4;

  // Supported Modbus function codes.
  localparam logic [7:0] FC_READ_COILS     = 8'd1;
  localparam logic [7:0] FC_READ_DISCRETE  = 8'd2;
  localparam logic [7:0] FC_READ_HOLDING   = 8'd3;
  localparam logic [7:0] FC_READ_INPUT     = 8'd4;
  localparam logic [7:0] FC_WRITE_COIL     = 8'd5;
  localparam logic [7:0] FC_WRITE_REGISTER = 8'd6;
  localparam logic [7:0] FC_WRITE_MULTIPLE = 8'd16;

  // Fixed frame sizes: a fixed-size request carries six header bytes, a code 16
  // request carries seven header bytes before its data, a read reply three.
  localparam logic [3:0] FIXED_REQ_BYTES  = 4'd6;
  localparam logic [9:0] MULTI_REQ_BYTES  = 10'd7;
  localparam logic [3:0] READ_HDR_BYTES   = 4'd3;
  localparam logic [3:0] WRITE_REPLY_BYTES = 4'd6;
  localparam logic [2:0] COILS_PER_BYTE_M1 = 3'd7;

  // Reset values of the registers.
  localparam logic [1:0] CHECKSUM_LEN_RST   = 2'd2;
  localparam logic [8:0] REPLY_CAPACITY_RST = 9'd256;

  // Header fields of one request.
  typedef struct packed {
    logic [7:0]  unit_address;
    logic [7:0]  function_code;
    logic [15:0] start_address;
    logic [15:0] quantity;
    logic [7:0]  byte_count;
    logic [8:0]  frame_length;
  } req_t;

  // One verdict.
  typedef struct packed {
    logic [2:0] status;
    logic [8:0] reply_length;
    logic       send_enable;
  } rsp_t;

  // Register set handed to the checking logic.
  typedef struct packed {
    logic [15:0] coil_count;
    logic [15:0] discrete_input_count;
    logic [15:0] holding_register_count;
    logic [15:0] input_register_count;
    logic [1:0]  checksum_length;
    logic [8:0]  reply_capacity;
  } cfg_t;

endpackage

@@ hw/rtl/mbrc_req_if.sv @@
// Request channel of the Modbus request checker: valid, ready and header fields.
// No dependencies.
interface mbrc_req_if;
  logic        valid;
  logic        ready;
  logic [7:0]  unit_address;
  logic [7:0]  function_code;
  logic [15:0] start_address;
  logic [15:0] quantity;
  logic [7:0]  byte_count;
  logic [8:0]  frame_length;

  modport source (
    output valid, unit_address, function_code, start_address, quantity,
           byte_count, frame_length,
    input  ready
  );
  modport sink (
    input  valid, unit_address, function_code, start_address, quantity,
           byte_count, frame_length,
    output ready
  );
endinterface

@@ hw/rtl/mbrc_rsp_if.sv @@
// Response channel of the Modbus request checker: valid, ready and verdict fields.
// No dependencies.
interface mbrc_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [8:0] reply_length;
  logic       send_enable;

  modport source (
    output valid, status, reply_length, send_enable,
    input  ready
  );
  modport sink (
    input  valid, status, reply_length, send_enable,
    output ready
  );
endinterface

@@ hw/rtl/mbrc_cfg_if.sv @@
// Configuration write channel of the Modbus request checker.
// No dependencies.
interface mbrc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

@@ hw/rtl/mbrc_cfg_regs.sv @@
// Configuration register file of the Modbus request checker.
// Depends on mbrc_pkg.
module mbrc_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 wr_en,
  input  logic [mbrc_pkg::CFG_INDEX_W-1:0]     wr_index,
  input  logic [mbrc_pkg::CFG_DATA_W-1:0]      wr_data,
  output mbrc_pkg::cfg_t                       cfg
);
  import mbrc_pkg::*;

  // Register write; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coil_count             <= '0;
      cfg.discrete_input_count   <= '0;
      cfg.holding_register_count <= '0;
      cfg.input_register_count   <= '0;
      cfg.checksum_length        <= CHECKSUM_LEN_RST;
      cfg.reply_capacity         <= REPLY_CAPACITY_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_COIL_COUNT:     cfg.coil_count             <= wr_data;
        REG_DISCRETE_COUNT: cfg.discrete_input_count   <= wr_data;
        REG_HOLDING_COUNT:  cfg.holding_register_count <= wr_data;
        REG_INPUT_COUNT:    cfg.input_register_count   <= wr_data;
        REG_CHECKSUM_LEN:   cfg.checksum_length        <= wr_data[1:0];
        REG_REPLY_CAPACITY: cfg.reply_capacity         <= wr_data[8:0];
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/mbrc_check.sv @@
// Combinational verdict logic of the Modbus request checker: format, address
// range, reply space and function code checks for one request header. Depends on mbrc_pkg.
module mbrc_check (
  input  mbrc_pkg::req_t req,
  input  mbrc_pkg::cfg_t cfg,
  output mbrc_pkg::rsp_t rsp
);
  import mbrc_pkg::*;

  logic [3:0]  fixed_len;
  logic        fixed_fmt_ok;
  logic [15:0] limit;
  logic [15:0] count;
  logic [16:0] end_addr;
  logic        start_bad;
  logic        range_bad;
  logic [16:0] coil_sum;
  logic [13:0] coil_len;
  logic [17:0] reg_len;
  logic        multi_fmt_ok;
  logic [9:0]  multi_len;
  logic [2:0]  status;
  logic [8:0]  len;

  // Length of a fixed-size request, which is also the write reply length.
  assign fixed_len    = FIXED_REQ_BYTES + {2'b00, cfg.checksum_length};
  assign fixed_fmt_ok = (req.frame_length == {5'b0, fixed_len});

  // Object limit that applies to this function.
  always_comb begin
    case (req.function_code)
      FC_READ_COILS, FC_WRITE_COIL:                        limit = cfg.coil_count;
      FC_READ_DISCRETE:                                    limit = cfg.discrete_input_count;
      FC_READ_HOLDING, FC_WRITE_REGISTER, FC_WRITE_MULTIPLE: limit = cfg.holding_register_count;
      FC_READ_INPUT:                                       limit = cfg.input_register_count;
      default:                                             limit = '0;
    endcase
  end

  // Code 16 counts only the low quantity byte; start plus count never wraps.
  assign count     = (req.function_code == FC_WRITE_MULTIPLE) ?
                     {8'b0, req.quantity[7:0]} : req.quantity;
  assign end_addr  = {1'b0, req.start_address} + {1'b0, count};
  assign start_bad = (req.start_address >= limit);
  assign range_bad = start_bad || (end_addr > {1'b0, limit});

  // Read reply lengths at full width, so an oversized count fails the space check.
  assign coil_sum = {1'b0, req.quantity} + {14'b0, COILS_PER_BYTE_M1};
  assign coil_len = {10'b0, READ_HDR_BYTES} + coil_sum[16:3] +
                    {12'b0, cfg.checksum_length};
  assign reg_len  = {14'b0, READ_HDR_BYTES} + {1'b0, req.quantity, 1'b0} +
                    {16'b0, cfg.checksum_length};

  // Code 16 format: byte count is twice the register count and matches the frame.
  assign multi_len    = {2'b0, req.byte_count} + MULTI_REQ_BYTES +
                        {8'b0, cfg.checksum_length};
  assign multi_fmt_ok = ({req.quantity[7:0], 1'b0} == {1'b0, req.byte_count}) &&
                        ({1'b0, req.frame_length} == multi_len);

  // Verdict and reply length per function.
  always_comb begin
    status = ST_OK;
    len    = '0;
    case (req.function_code)
      FC_READ_COILS, FC_READ_DISCRETE: begin
        if (!fixed_fmt_ok) begin
          status = ST_FORMAT;
        end else if (range_bad) begin
          status = ST_ADDR;
        end else if (coil_len > {5'b0, cfg.reply_capacity}) begin
          status = ST_SPACE;
        end else begin
          len = coil_len[8:0];
        end
      end
      FC_READ_HOLDING, FC_READ_INPUT: begin
        if (!fixed_fmt_ok) begin
          status = ST_FORMAT;
        end else if (range_bad) begin
          status = ST_ADDR;
        end else if (reg_len > {9'b0, cfg.reply_capacity}) begin
          status = ST_SPACE;
        end else begin
          len = reg_len[8:0];
        end
      end
      FC_WRITE_COIL, FC_WRITE_REGISTER: begin
        if (!fixed_fmt_ok) begin
          status = ST_FORMAT;
        end else if (start_bad) begin
          status = ST_ADDR;
        end else begin
          len = {5'b0, fixed_len};
        end
      end
      FC_WRITE_MULTIPLE: begin
        if (!multi_fmt_ok) begin
          status = ST_FORMAT;
        end else if (range_bad) begin
          status = ST_ADDR;
        end else begin
          len = {5'b0, fixed_len};
        end
      end
      default: status = ST_UNSUPPORTED;
    endcase
  end

  // Broadcast requests are checked but never answered.
  assign rsp.status       = status;
  assign rsp.reply_length = len;
  assign rsp.send_enable  = (status == ST_OK) && (req.unit_address != 8'd0);

endmodule

@@ hw/rtl/modbus_request_checker.sv @@
// Modbus request checker: one verdict beat for every request header beat, giving
// status, reply length with checksum and a send flag. A request passes from acceptance
// to its verdict through the input register, then the result register, and one
// request is accepted in every cycle as long as the verdicts are taken; the
// result register taking its next beat is what sets the rate. Configuration
// writes are accepted in any cycle and must be made while no request is in flight.
// Depends on mbrc_pkg, mbrc_req_if, mbrc_rsp_if, mbrc_cfg_if, mbrc_cfg_regs, mbrc_check.
module modbus_request_checker (
  input  logic       clk,
  input  logic       rst,
  mbrc_req_if.sink   req,
  mbrc_rsp_if.source rsp,
  mbrc_cfg_if.sink   cfg
);
  import mbrc_pkg::*;

  cfg_t cfg_q;
  req_t req_in;
  req_t s1_req;
  logic s1_valid;
  rsp_t s1_rsp;
  rsp_t rsp_q;
  logic rsp_valid;
  logic out_ready;
  logic s1_adv;

  // Configuration registers; writes never stall.
  assign cfg.ready = 1'b1;

  mbrc_cfg_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_q)
  );

  // Flow control: the result register frees when empty or taken this cycle,
  // and the input register frees when its beat moves on.
  assign out_ready = !rsp_valid || rsp.ready;
  assign s1_adv    = s1_valid && out_ready;
  assign req.ready = !s1_valid || out_ready;

  assign req_in.unit_address  = req.unit_address;
  assign req_in.function_code = req.function_code;
  assign req_in.start_address = req.start_address;
  assign req_in.quantity      = req.quantity;
  assign req_in.byte_count    = req.byte_count;
  assign req_in.frame_length  = req.frame_length;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_req <= req_in;
    end
  end

  mbrc_check u_check (
    .req (s1_req),
    .cfg (cfg_q),
    .rsp (s1_rsp)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_ready) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rsp_q <= s1_rsp;
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.status       = rsp_q.status;
  assign rsp.reply_length = rsp_q.reply_length;
  assign rsp.send_enable  = rsp_q.send_enable;

  // An accepted request always lands in the input register.
  assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> s1_valid)
    else $error("accepted request beat lost before the input register");

  // A beat leaving the input register always shows up as a verdict.
  assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> rsp.valid)
    else $error("checked beat did not reach the result register");

  // A failed verdict carries no reply length and is never sent.
  assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status != ST_OK)) |->
      ((rsp.reply_length == 9'd0) && !rsp.send_enable))
    else $error("failed verdict with reply length or send flag set");

endmodule
